@@ hw/rtl/ttba_pkg.sv @@
package ttba_pkg;

   // Size of the bar grid per market
   localparam int BARS_DEFAULT = 32;

   // Field widths
   localparam int TIME_W  = 63;
   localparam int PRICE_W = 48;
   localparam int SUM_W   = 63;
   localparam int SSUM_W  = 64;
   localparam int CNT_W   = 32;
   localparam int IVL_W   = 40;
   localparam int NBAR_W  = 6;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 64;

   // Result status codes
   localparam logic [1:0] ST_BAR     = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_ORDER   = 2'd2;

   // Input word kinds
   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Register indexes (byte address divided by 8)
   localparam logic [1:0] REG_GRID_START   = 2'd0;
   localparam logic [1:0] REG_BAR_INTERVAL = 2'd1;
   localparam logic [1:0] REG_BARS_IN_USE  = 2'd2;

   localparam logic [IVL_W-1:0]  INTERVAL_RESET = IVL_W'(1000000000);
   localparam logic [NBAR_W-1:0] BARS_RESET     = NBAR_W'(32);

   // One stored bar
   typedef struct packed {
      logic [PRICE_W-1:0]       price;
      logic [SUM_W-1:0]         qsum;
      logic [SUM_W-1:0]         nsum;
      logic signed [SSUM_W-1:0] sqsum;
      logic signed [SSUM_W-1:0] snsum;
      logic [CNT_W-1:0]         total;
      logic [CNT_W-1:0]         buys;
      logic [CNT_W-1:0]         sells;
   } bar_type;

   localparam int BAR_W = $bits(bar_type);

   // Saturating unsigned add, stops at 2^63-1
   function automatic logic [SUM_W-1:0] sat_add_u63(input logic [SUM_W-1:0] a,
                                                    input logic [PRICE_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W+1-PRICE_W){1'b0}}, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   // Saturating signed add, stops at the 64-bit limits
   function automatic logic signed [SSUM_W-1:0] sat_add_s64(
      input logic signed [SSUM_W-1:0] a, input logic signed [PRICE_W-1:0] b);
      logic [SSUM_W:0] s;
      s = {a[SSUM_W-1], a} + {{(SSUM_W+1-PRICE_W){b[PRICE_W-1]}}, b};
      if (s[SSUM_W] != s[SSUM_W-1])
         return s[SSUM_W] ? {1'b1, {(SSUM_W-1){1'b0}}} : {1'b0, {(SSUM_W-1){1'b1}}};
      return s[SSUM_W-1:0];
   endfunction

   // Saturating count
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
   endfunction

endpackage

@@ hw/rtl/trade_time_bar_aggregator_unit.sv @@
// Time-bar aggregator for two markets. A trade word is accepted only while the block is
// idle; one shared 63-bit subtract and compare walks the remaining time down one bar
// interval per cycle before a read-modify-write of the bar RAM. A rejected trade gives
// one status word when the order or grid-start check fails, the interval is zero, or
// the walk runs past the last bar, after any wait for the result side. A readout word
// gives one result word per bar in use, each after its read through the single
// registered read port of the bar RAM, waiting while the result side does not take them.
// Bars are cleared at reset through per-entry valid bits, with no clearing pass.
module trade_time_bar_aggregator_unit #(
   parameter int BARS_PER_MARKET = ttba_pkg::BARS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic                                req_market_select,
   input  logic [ttba_pkg::TIME_W-1:0]         req_event_time,
   input  logic [ttba_pkg::PRICE_W-1:0]        req_trade_price,
   input  logic [ttba_pkg::PRICE_W-1:0]        req_trade_quantity,
   input  logic [ttba_pkg::PRICE_W-1:0]        req_trade_notional,
   input  logic signed [ttba_pkg::PRICE_W-1:0] req_signed_qty_in,
   input  logic signed [ttba_pkg::PRICE_W-1:0] req_signed_notional_in,
   input  logic                                req_buyer_is_maker,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [4:0]                          rsp_bar_index,
   output logic                                rsp_price_valid,
   output logic [ttba_pkg::PRICE_W-1:0]        rsp_bar_price,
   output logic [ttba_pkg::SUM_W-1:0]          rsp_quantity_sum,
   output logic [ttba_pkg::SUM_W-1:0]          rsp_notional_sum,
   output logic signed [ttba_pkg::SSUM_W-1:0]  rsp_signed_qty_sum,
   output logic signed [ttba_pkg::SSUM_W-1:0]  rsp_signed_notional_sum,
   output logic [ttba_pkg::CNT_W-1:0]          rsp_trade_total,
   output logic [ttba_pkg::CNT_W-1:0]          rsp_buyer_trades,
   output logic [ttba_pkg::CNT_W-1:0]          rsp_seller_trades,
   output logic                                rsp_last_of_run,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ttba_pkg::CSR_AW-1:0]         paddr,
   input  logic [ttba_pkg::CSR_DW-1:0]         pwdata,
   output logic [ttba_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import ttba_pkg::*;

   localparam int DEPTH  = 2 * BARS_PER_MARKET;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int K_W    = $clog2(BARS_PER_MARKET + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_STAT = 3'd5;
   localparam logic [2:0] S_RORD = 3'd6;
   localparam logic [2:0] S_ROLD = 3'd7;

   // configuration registers
   logic [TIME_W-1:0] grid_start_ff;
   logic [IVL_W-1:0]  interval_ff;
   logic [NBAR_W-1:0] bars_ff;

   // sequencer and item registers
   logic [2:0]         state_ff, state_in;
   logic               market_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [PRICE_W-1:0] price_ff, qty_ff, notional_ff;
   logic signed [PRICE_W-1:0] sq_ff, sn_ff;
   logic               maker_ff;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [1:0]         stat_ff, stat_in;
   logic [TIME_W-1:0]  last_time_ff [2];
   logic [DEPTH-1:0]   valid_ff;
   logic               fill_valid_ff;
   logic [PRICE_W-1:0] fill_price_ff;
   logic               rsp_valid_ff;

   logic [6:0]         bars_clip;
   logic [K_W-1:0]     nb_eff;
   logic [ADDR_W-1:0]  addr;
   logic               slot_free;
   logic               ram_we, ram_re;
   bar_type            ram_rd, old_bar, new_bar;
   logic               cfg_wr;

   // Clamp bars in use into 1..BARS_PER_MARKET
   always_comb begin
      bars_clip = {1'b0, bars_ff};
      if (bars_clip == 7'd0) begin
         bars_clip = 7'd1;
      end else if (bars_clip > 7'(BARS_PER_MARKET)) begin
         bars_clip = 7'(BARS_PER_MARKET);
      end
   end
   assign nb_eff = K_W'(bars_clip);

   assign addr      = (market_ff ? ADDR_W'(BARS_PER_MARKET) : '0) + ADDR_W'(k_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign ram_re    = (state_ff == S_RD) || (state_ff == S_RORD);
   assign ram_we    = (state_ff == S_UPD);
   assign old_bar   = valid_ff[addr] ? ram_rd : '0;

   // Fold the trade into the bar
   always_comb begin
      new_bar       = old_bar;
      new_bar.price = price_ff;
      new_bar.qsum  = sat_add_u63(old_bar.qsum, qty_ff);
      new_bar.nsum  = sat_add_u63(old_bar.nsum, notional_ff);
      new_bar.sqsum = sat_add_s64(old_bar.sqsum, sq_ff);
      new_bar.snsum = sat_add_s64(old_bar.snsum, sn_ff);
      new_bar.total = sat_inc(old_bar.total);
      if (maker_ff) begin
         new_bar.sells = sat_inc(old_bar.sells);
      end else begin
         new_bar.buys = sat_inc(old_bar.buys);
      end
   end

   ttba_ram #(
      .WIDTH (BAR_W),
      .DEPTH (DEPTH)
   ) u_bar_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (new_bar),
      .rd_en   (ram_re),
      .rd_addr (addr),
      .rd_data (ram_rd)
   );

   // Sequencer: check, divide by repeated subtract, then update or report, or read out the bars
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      stat_in  = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            k_in = '0;
            if (req_valid) begin
               state_in = (req_kind == KIND_READ) ? S_RORD : S_CHK;
            end
         end
         S_CHK: begin
            rem_in = time_ff - grid_start_ff;
            if (time_ff < last_time_ff[market_ff]) begin
               stat_in  = ST_ORDER;
               state_in = S_STAT;
            end else if (interval_ff == '0 || time_ff < grid_start_ff) begin
               stat_in  = ST_OUTSIDE;
               state_in = S_STAT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ff < {{(TIME_W-IVL_W){1'b0}}, interval_ff}) begin
               state_in = S_RD;
            end else if (k_ff == nb_eff - K_W'(1)) begin
               stat_in  = ST_OUTSIDE;
               state_in = S_STAT;
            end else begin
               rem_in = rem_ff - {{(TIME_W-IVL_W){1'b0}}, interval_ff};
               k_in   = k_ff + K_W'(1);
            end
         end
         S_RD:   state_in = S_UPD;
         S_UPD:  state_in = S_IDLE;
         S_STAT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_RORD: state_in = S_ROLD;
         S_ROLD: begin
            if (slot_free) begin
               k_in     = k_ff + K_W'(1);
               state_in = (k_ff == nb_eff - K_W'(1)) ? S_IDLE : S_RORD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         valid_ff        <= '0;
         last_time_ff[0] <= '0;
         last_time_ff[1] <= '0;
         fill_valid_ff   <= 1'b0;
         fill_price_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         // mark bar and advance the market's time
         if (ram_we) begin
            valid_ff[addr]          <= 1'b1;
            last_time_ff[market_ff] <= time_ff;
         end
         // restart the forward fill on readout
         if (state_ff == S_IDLE && req_valid && req_kind == KIND_READ) begin
            fill_valid_ff <= 1'b0;
            fill_price_ff <= '0;
         end else if (state_ff == S_ROLD && slot_free && valid_ff[addr]) begin
            fill_valid_ff <= 1'b1;
            fill_price_ff <= ram_rd.price;
         end
         // hold the result word until taken
         if ((state_ff == S_STAT || state_ff == S_ROLD) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the word and step the divider
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      stat_ff <= stat_in;
      if (state_ff == S_IDLE && req_valid) begin
         market_ff   <= req_market_select;
         time_ff     <= req_event_time;
         price_ff    <= req_trade_price;
         qty_ff      <= req_trade_quantity;
         notional_ff <= req_trade_notional;
         sq_ff       <= req_signed_qty_in;
         sn_ff       <= req_signed_notional_in;
         maker_ff    <= req_buyer_is_maker;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (state_ff == S_STAT && slot_free) begin
         rsp_status              <= stat_ff;
         rsp_bar_index           <= '0;
         rsp_price_valid         <= 1'b0;
         rsp_bar_price           <= '0;
         rsp_quantity_sum        <= '0;
         rsp_notional_sum        <= '0;
         rsp_signed_qty_sum      <= '0;
         rsp_signed_notional_sum <= '0;
         rsp_trade_total         <= '0;
         rsp_buyer_trades        <= '0;
         rsp_seller_trades       <= '0;
         rsp_last_of_run         <= 1'b1;
      end else if (state_ff == S_ROLD && slot_free) begin
         rsp_status              <= ST_BAR;
         rsp_bar_index           <= 5'(k_ff);
         rsp_price_valid         <= valid_ff[addr] || fill_valid_ff;
         rsp_bar_price           <= valid_ff[addr] ? ram_rd.price : fill_price_ff;
         rsp_quantity_sum        <= old_bar.qsum;
         rsp_notional_sum        <= old_bar.nsum;
         rsp_signed_qty_sum      <= old_bar.sqsum;
         rsp_signed_notional_sum <= old_bar.snsum;
         rsp_trade_total         <= old_bar.total;
         rsp_buyer_trades        <= old_bar.buys;
         rsp_seller_trades       <= old_bar.sells;
         rsp_last_of_run         <= (k_ff == nb_eff - K_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Register writes and reads
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_start_ff <= '0;
         interval_ff   <= INTERVAL_RESET;
         bars_ff       <= BARS_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[4:3])
            REG_GRID_START:   grid_start_ff <= pwdata[TIME_W-1:0];
            REG_BAR_INTERVAL: interval_ff   <= pwdata[IVL_W-1:0];
            REG_BARS_IN_USE:  bars_ff       <= pwdata[NBAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_GRID_START:   prdata = {1'b0, grid_start_ff};
         REG_BAR_INTERVAL: prdata = {{(CSR_DW-IVL_W){1'b0}}, interval_ff};
         REG_BARS_IN_USE:  prdata = {{(CSR_DW-NBAR_W){1'b0}}, bars_ff};
         default:          prdata = '0;
      endcase
   end

   // The divider never walks past the bars in use
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (k_ff < nb_eff))
      else $error("divider index beyond bars in use");

   // A bar write leaves that bar valid
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(addr)])
      else $error("bar written but not marked valid");

   // A status word always closes its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status != ST_BAR) |-> rsp_last_of_run)
      else $error("status word without last_of_run");

   // No new word is taken while a readout is under way
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RORD || state_ff == S_ROLD) |-> !req_ready)
      else $error("ready during readout");

endmodule

@@ hw/rtl/ttba_ram.sv @@
module ttba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
